>>> design/bchj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchj_pkg
// Shared types, sizes and the slot remainder step of the bucket-chain hash join.
// ----------------------------------------------------------------------------
package bchj_pkg;

	localparam int ROW_W        = 32;
	localparam int VALUE_W      = 31;
	localparam int AUX_W        = 32;
	localparam int HASH_MODULUS = 23;
	localparam int BUCKET_DEPTH = 64;
	localparam int MAX_RESULTS  = 64;

	localparam int ADDR_W     = $clog2(BUCKET_DEPTH);
	localparam int CNT_W      = $clog2(BUCKET_DEPTH + 1);
	localparam int SLOT_W     = $clog2(HASH_MODULUS);
	localparam int DIG_W      = SLOT_W + 4;
	localparam int NUM_DIGITS = (VALUE_W + 3) / 4;
	localparam int SHIFT_W    = 4 * NUM_DIGITS;
	localparam int DCNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int RES_W      = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_BUILD,
		ST_HEAD,
		ST_CHECK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic               link_ok;
		logic [ADDR_W-1:0]  link;
		logic [ROW_W-1:0]   row_id;
		logic [VALUE_W-1:0] value;
		logic [AUX_W-1:0]   aux;
	} entry_t;

	// one radix-16 digit of the remainder: (rem * 16 + digit) mod HASH_MODULUS
	function automatic logic [SLOT_W-1:0] mod_digit(input logic [SLOT_W-1:0] rem,
			input logic [3:0] digit);
		logic [DIG_W-1:0] x;
		logic [DIG_W-1:0] r;
		x = {rem, digit};
		r = x;
		for (int k = 1; k < 16; k++) begin
			if (x >= DIG_W'(k * HASH_MODULUS)) begin
				r = x - DIG_W'(k * HASH_MODULUS);
			end
		end
		return r[SLOT_W-1:0];
	endfunction

endpackage

>>> design/bucket_chain_hash_join.sv
`timescale 1ns / 1ps
// build: busy through 8 remainder digit steps, then 1 store and head update
// probe: busy through 8 remainder digit steps and a head lookup; on an occupied slot a chain walk and a flush follow;
//   the walk reads one stored entry per cycle through the single entry memory read port
// each result is registered out at the next match, or from the flush state after the walk ends; no stall
// reset clears head valid flags, build count, overflow flag and index_on_a; entry memory is not cleared
// ----------------------------------------------------------------------------
// bucket_chain_hash_join
// Bucket-chain hash index over build tuples, probed by the other relation.
// ----------------------------------------------------------------------------
module bucket_chain_hash_join
	import bchj_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic               starts_bucket,
	input  logic [ROW_W-1:0]   row_id,
	input  logic [VALUE_W-1:0] value,
	input  logic [AUX_W-1:0]   aux_index,
	output logic               result_strobe,
	output logic [ROW_W-1:0]   a_row_id,
	output logic [VALUE_W-1:0] a_value,
	output logic [AUX_W-1:0]   a_aux,
	output logic [ROW_W-1:0]   b_row_id,
	output logic [VALUE_W-1:0] b_value,
	output logic [AUX_W-1:0]   b_aux,
	output logic               last,
	output logic               overflowed
);

	state_t state_q, state_d;

	logic               index_on_a_q;
	logic               func_q;
	logic [ROW_W-1:0]   row_q;
	logic [VALUE_W-1:0] value_q;
	logic [AUX_W-1:0]   aux_q;
	logic [SHIFT_W-1:0] val_sh_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [SLOT_W-1:0]  rem_q;

	logic [ADDR_W-1:0]  head_q [HASH_MODULUS];
	logic [HASH_MODULUS-1:0] head_valid_q;
	logic [CNT_W-1:0]   build_count_q;
	logic               overflow_q;

	entry_t             mem [BUCKET_DEPTH];
	entry_t             rd_q;
	entry_t             wr_entry;
	logic [ADDR_W-1:0]  rd_addr;
	logic               mem_we;

	logic               pend_valid_q;
	logic [ROW_W-1:0]   pend_row_q;
	logic [AUX_W-1:0]   pend_aux_q;
	logic [RES_W-1:0]   n_q;

	logic               accept;
	logic               full;
	logic               match;
	logic               emit;
	logic               emit_last;

	logic               res_strobe_q;
	logic [ROW_W-1:0]   a_row_q, b_row_q;
	logic [VALUE_W-1:0] a_value_q, b_value_q;
	logic [AUX_W-1:0]   a_aux_q, b_aux_q;
	logic               last_q;
	logic               ovf_out_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (build_count_q == CNT_W'(BUCKET_DEPTH));
	assign match  = (rd_q.value == value_q);

	assign wr_entry.link_ok = head_valid_q[rem_q];
	assign wr_entry.link    = head_q[rem_q];
	assign wr_entry.row_id  = row_q;
	assign wr_entry.value   = value_q;
	assign wr_entry.aux     = aux_q;

	assign rd_addr = (state_q == ST_HEAD) ? head_q[rem_q] : rd_q.link;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		mem_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (dcnt_q == DCNT_W'(NUM_DIGITS - 1)) begin
					state_d = func_q ? ST_HEAD : ST_BUILD;
				end
			end
			ST_BUILD: begin
				mem_we  = !full;
				state_d = ST_IDLE;
			end
			ST_HEAD: begin
				state_d = head_valid_q[rem_q] ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				// a found match is held back until we know whether it is the final one
				emit = match && pend_valid_q;
				if (!rd_q.link_ok || (match && n_q == RES_W'(MAX_RESULTS - 1))) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				emit      = pend_valid_q;
				emit_last = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_on_a_q  <= 1'b0;
			head_valid_q  <= '0;
			build_count_q <= '0;
			overflow_q    <= 1'b0;
			pend_valid_q  <= 1'b0;
			n_q           <= '0;
			dcnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				index_on_a_q <= cfg_wdata;
			end
			if (accept) begin
				dcnt_q       <= '0;
				pend_valid_q <= 1'b0;
				n_q          <= '0;
				if (!func && starts_bucket) begin
					head_valid_q  <= '0;
					build_count_q <= '0;
				end
			end
			if (state_q == ST_HASH) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (state_q == ST_BUILD) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					head_valid_q[rem_q] <= 1'b1;
					build_count_q       <= build_count_q + 1'b1;
				end
			end
			if (state_q == ST_CHECK && match) begin
				pend_valid_q <= 1'b1;
				n_q          <= n_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			row_q    <= row_id;
			value_q  <= value;
			aux_q    <= aux_index;
			val_sh_q <= SHIFT_W'(value);
			rem_q    <= '0;
		end
		if (state_q == ST_HASH) begin
			rem_q    <= mod_digit(rem_q, val_sh_q[SHIFT_W-1 -: 4]);
			val_sh_q <= val_sh_q << 4;
		end
		if (state_q == ST_BUILD && !full) begin
			head_q[rem_q] <= build_count_q[ADDR_W-1:0];
		end
		if (state_q == ST_CHECK && match) begin
			pend_row_q <= rd_q.row_id;
			pend_aux_q <= rd_q.aux;
		end
	end

	// entry store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[build_count_q[ADDR_W-1:0]] <= wr_entry;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_strobe_q <= 1'b0;
		end else begin
			res_strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			last_q    <= emit_last;
			ovf_out_q <= overflow_q;
			if (index_on_a_q) begin
				a_row_q   <= pend_row_q;
				a_value_q <= value_q;
				a_aux_q   <= pend_aux_q;
				b_row_q   <= row_q;
				b_value_q <= value_q;
				b_aux_q   <= aux_q;
			end else begin
				a_row_q   <= row_q;
				a_value_q <= value_q;
				a_aux_q   <= aux_q;
				b_row_q   <= pend_row_q;
				b_value_q <= value_q;
				b_aux_q   <= pend_aux_q;
			end
		end
	end

	assign result_strobe = res_strobe_q;
	assign a_row_id      = a_row_q;
	assign a_value       = a_value_q;
	assign a_aux         = a_aux_q;
	assign b_row_id      = b_row_q;
	assign b_value       = b_value_q;
	assign b_aux         = b_aux_q;
	assign last          = last_q;
	assign overflowed    = ovf_out_q;

endmodule

>>> design/bchj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchj_checker
// Port-level checks on the bucket-chain hash join, bound to the top level.
// ----------------------------------------------------------------------------
module bchj_props (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_strobe,
	input logic last
);

	// an accepted transaction always leaves the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after an accepted transaction");

	// results only follow work done in the previous cycle
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without preceding work");

	// more results pending means the walk is still going
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> busy)
		else $error("non-final result while idle");

	// the final result of a probe finds the block ready again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |-> !busy)
		else $error("final result while still busy");

endmodule

bind bucket_chain_hash_join bchj_props u_bchj_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.last          (last)
);

>>> verif/bchj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bchj_checker
// Keeps a private bucket-chain index fed from the accepted build transactions,
// walks it for every accepted probe and checks each emitted pair in order.
// ----------------------------------------------------------------------------
package bchj_tb_pkg;

	typedef enum logic {
		FUNC_BUILD = 1'b0,
		FUNC_PROBE = 1'b1
	} join_func_t;

endpackage

module bchj_checker
	import bchj_pkg::*;
	import bchj_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               start,
	input  logic               busy,
	input  logic               func,
	input  logic               starts_bucket,
	input  logic [ROW_W-1:0]   row_id,
	input  logic [VALUE_W-1:0] value,
	input  logic [AUX_W-1:0]   aux_index,
	input  logic               result_strobe,
	input  logic [ROW_W-1:0]   a_row_id,
	input  logic [VALUE_W-1:0] a_value,
	input  logic [AUX_W-1:0]   a_aux,
	input  logic [ROW_W-1:0]   b_row_id,
	input  logic [VALUE_W-1:0] b_value,
	input  logic [AUX_W-1:0]   b_aux,
	input  logic               last,
	input  logic               overflowed,
	output int                 fail_count,
	output int                 outstanding,
	output int                 pairs_checked
);

	typedef struct packed {
		logic [ROW_W-1:0]   a_row_id;
		logic [VALUE_W-1:0] a_value;
		logic [AUX_W-1:0]   a_aux;
		logic [ROW_W-1:0]   b_row_id;
		logic [VALUE_W-1:0] b_value;
		logic [AUX_W-1:0]   b_aux;
		logic               last;
		logic               overflowed;
	} join_pair_t;

	logic [ADDR_W-1:0]  head_pos  [HASH_MODULUS];
	logic               head_ok   [HASH_MODULUS];
	logic [ADDR_W-1:0]  link_pos  [BUCKET_DEPTH];
	logic               link_ok   [BUCKET_DEPTH];
	logic [ROW_W-1:0]   ent_row   [BUCKET_DEPTH];
	logic [VALUE_W-1:0] ent_value [BUCKET_DEPTH];
	logic [AUX_W-1:0]   ent_aux   [BUCKET_DEPTH];
	int                 fill_count;
	logic               full_seen;
	logic               build_is_a;
	join_pair_t         pair_q [$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		fail_count++;
		if (fail_count <= 20) begin
			$display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
		end
	endtask

	task automatic add_tuple(input logic sb, input logic [ROW_W-1:0] r,
			input logic [VALUE_W-1:0] v, input logic [AUX_W-1:0] a);
		int slot;
		slot = int'(v % VALUE_W'(HASH_MODULUS));
		if (sb) begin
			foreach (head_ok[i]) head_ok[i] = 1'b0;
			fill_count = 0;
		end
		if (fill_count >= BUCKET_DEPTH) begin
			full_seen = 1'b1;
		end else begin
			ent_row[fill_count]   = r;
			ent_value[fill_count] = v;
			ent_aux[fill_count]   = a;
			// new entry becomes the head, so walks go from newest to oldest
			link_pos[fill_count]  = head_pos[slot];
			link_ok[fill_count]   = head_ok[slot];
			head_pos[slot]        = ADDR_W'(fill_count);
			head_ok[slot]         = 1'b1;
			fill_count++;
		end
	endtask

	task automatic walk_chain(input logic [ROW_W-1:0] r, input logic [VALUE_W-1:0] v,
			input logic [AUX_W-1:0] a);
		int                slot;
		int                steps;
		int                hits;
		logic              have;
		logic              held_ok;
		logic [ADDR_W-1:0] pos;
		join_pair_t        held;
		join_pair_t        hit;
		slot    = int'(v % VALUE_W'(HASH_MODULUS));
		have    = head_ok[slot];
		pos     = head_pos[slot];
		steps   = 0;
		hits    = 0;
		held_ok = 1'b0;
		held    = '0;
		while (have && steps < BUCKET_DEPTH && hits < MAX_RESULTS) begin
			if (ent_value[pos] == v) begin
				if (build_is_a) begin
					hit.a_row_id = ent_row[pos];
					hit.a_value  = ent_value[pos];
					hit.a_aux    = ent_aux[pos];
					hit.b_row_id = r;
					hit.b_value  = v;
					hit.b_aux    = a;
				end else begin
					hit.a_row_id = r;
					hit.a_value  = v;
					hit.a_aux    = a;
					hit.b_row_id = ent_row[pos];
					hit.b_value  = ent_value[pos];
					hit.b_aux    = ent_aux[pos];
				end
				hit.last       = 1'b0;
				hit.overflowed = full_seen;
				// hold one back so the final match of the walk can get last set
				if (held_ok) begin
					pair_q.push_back(held);
				end
				held    = hit;
				held_ok = 1'b1;
				hits++;
			end
			have = link_ok[pos];
			pos  = link_pos[pos];
			steps++;
		end
		if (held_ok) begin
			held.last = 1'b1;
			pair_q.push_back(held);
		end
	endtask

	task automatic check_pair();
		join_pair_t want;
		if (pair_q.size() == 0) begin
			report("pair with none expected", 64'(a_value), 64'(b_value));
		end else begin
			want = pair_q.pop_front();
			pairs_checked++;
			if (a_row_id !== want.a_row_id)
				report("a_row_id", 64'(a_row_id), 64'(want.a_row_id));
			if (a_value !== want.a_value)
				report("a_value", 64'(a_value), 64'(want.a_value));
			if (a_aux !== want.a_aux)
				report("a_aux", 64'(a_aux), 64'(want.a_aux));
			if (b_row_id !== want.b_row_id)
				report("b_row_id", 64'(b_row_id), 64'(want.b_row_id));
			if (b_value !== want.b_value)
				report("b_value", 64'(b_value), 64'(want.b_value));
			if (b_aux !== want.b_aux)
				report("b_aux", 64'(b_aux), 64'(want.b_aux));
			if (last !== want.last)
				report("last", 64'(last), 64'(want.last));
			if (overflowed !== want.overflowed)
				report("overflowed", 64'(overflowed), 64'(want.overflowed));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (head_ok[i]) begin
				head_ok[i]  = 1'b0;
				head_pos[i] = '0;
			end
			foreach (link_ok[i]) begin
				link_ok[i]  = 1'b0;
				link_pos[i] = '0;
			end
			fill_count    = 0;
			full_seen     = 1'b0;
			build_is_a    = 1'b0;
			fail_count    = 0;
			pairs_checked = 0;
			pair_q.delete();
			outstanding   = 0;
		end else begin
			// retire results first: a new transaction can land on the edge of a last pair
			if (result_strobe) begin
				check_pair();
			end
			if (cfg_we) begin
				build_is_a = cfg_wdata;
			end
			if (start && !busy) begin
				if (func == FUNC_PROBE) begin
					walk_chain(row_id, value, aux_index);
				end else begin
					add_tuple(starts_bucket, row_id, value, aux_index);
				end
			end
			outstanding = pair_q.size();
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives build and probe transactions into the hash join: a directed opener,
// random partitions under three sender idle profiles, then a store overflow.
// ----------------------------------------------------------------------------
module tb;
	import bchj_pkg::*;
	import bchj_tb_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 100;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_we        = 1'b0;
	logic               cfg_wdata     = 1'b0;
	logic               start         = 1'b0;
	logic               func          = 1'b0;
	logic               starts_bucket = 1'b0;
	logic [ROW_W-1:0]   row_id        = '0;
	logic [VALUE_W-1:0] value         = '0;
	logic [AUX_W-1:0]   aux_index     = '0;
	logic               busy;
	logic               result_strobe;
	logic [ROW_W-1:0]   a_row_id;
	logic [VALUE_W-1:0] a_value;
	logic [AUX_W-1:0]   a_aux;
	logic [ROW_W-1:0]   b_row_id;
	logic [VALUE_W-1:0] b_value;
	logic [AUX_W-1:0]   b_aux;
	logic               last;
	logic               overflowed;

	int fail_count;
	int outstanding;
	int pairs_checked;
	int idle_pct     = 0;
	int build_total  = 0;
	int probe_total  = 0;
	int side_writes  = 0;
	int phase_items  = 0;
	int index_fill   = 0;
	int stall_cycles = 0;

	always #2 clk = ~clk;

	bucket_chain_hash_join i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.starts_bucket (starts_bucket),
		.row_id        (row_id),
		.value         (value),
		.aux_index     (aux_index),
		.result_strobe (result_strobe),
		.a_row_id      (a_row_id),
		.a_value       (a_value),
		.a_aux         (a_aux),
		.b_row_id      (b_row_id),
		.b_value       (b_value),
		.b_aux         (b_aux),
		.last          (last),
		.overflowed    (overflowed)
	);

	bchj_checker i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.starts_bucket (starts_bucket),
		.row_id        (row_id),
		.value         (value),
		.aux_index     (aux_index),
		.result_strobe (result_strobe),
		.a_row_id      (a_row_id),
		.a_value       (a_value),
		.a_aux         (a_aux),
		.b_row_id      (b_row_id),
		.b_value       (b_value),
		.b_aux         (b_aux),
		.last          (last),
		.overflowed    (overflowed),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.pairs_checked (pairs_checked)
	);

	// watchdog: any transaction in either direction restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("bucket_chain_hash_join regression: fail");
			$finish;
		end
	end

	// each cycle the sender holds start low with a chance of idle_pct in a hundred
	task automatic issue(input join_func_t f, input logic sb, input logic [ROW_W-1:0] r,
			input logic [VALUE_W-1:0] v, input logic [AUX_W-1:0] a);
		func          <= f;
		starts_bucket <= sb;
		row_id        <= r;
		value         <= v;
		aux_index     <= a;
		do begin
			start <= ($urandom_range(99) >= idle_pct);
			@(posedge clk);
		end while (!start || busy);
		if (f == FUNC_PROBE) begin
			probe_total++;
		end else begin
			build_total++;
			if (sb) index_fill = 0;
			if (index_fill < BUCKET_DEPTH) index_fill++;
		end
		phase_items++;
	endtask

	task automatic build(input logic sb, input logic [VALUE_W-1:0] v);
		issue(FUNC_BUILD, sb, $urandom, v, $urandom);
	endtask

	task automatic probe(input logic [VALUE_W-1:0] v);
		issue(FUNC_PROBE, 1'($urandom_range(1)), $urandom, v, $urandom);
	endtask

	// builds cause no pairs, so busy must drop too before the block is idle
	task automatic drain();
		start <= 1'b0;
		do begin
			@(negedge clk);
		end while (outstanding != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_side(input logic a_side);
		cfg_we    <= 1'b1;
		cfg_wdata <= a_side;
		@(posedge clk);
		cfg_we    <= 1'b0;
		side_writes++;
	endtask

	task automatic run_partition();
		int                 n_build;
		int                 n_probe;
		logic               fresh;
		logic [VALUE_W-1:0] k;
		logic [VALUE_W-1:0] keys [$];
		for (int i = 0; i < $urandom_range(4, 1); i++) begin
			k = VALUE_W'($urandom_range(32'h7FFF_FF00, 0));
			keys.push_back(k);
			// same slot, different value
			keys.push_back(k + VALUE_W'(HASH_MODULUS * $urandom_range(8, 1)));
		end
		n_build = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
		n_probe = $urandom_range(12, 1);
		// now and then keep adding to the previous partition, as long as it fits
		fresh = !($urandom_range(9) == 0 && index_fill + n_build <= BUCKET_DEPTH);
		for (int i = 0; i < n_build; i++) begin
			build(fresh && i == 0, keys[$urandom_range(keys.size() - 1)]);
		end
		for (int i = 0; i < n_probe; i++) begin
			if ($urandom_range(99) < 85) begin
				probe(keys[$urandom_range(keys.size() - 1)]);
			end else begin
				probe(VALUE_W'($urandom));
			end
		end
	endtask

	initial begin
		logic [VALUE_W-1:0] k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_side(1'b0);

		// directed opener: empty index, field extremes, slot collisions, duplicates
		issue(FUNC_PROBE, 1'b1, '1, VALUE_W'(5), '1);
		issue(FUNC_BUILD, 1'b1, '0, '0, '0);
		issue(FUNC_BUILD, 1'b0, '1, '1, '1);
		issue(FUNC_BUILD, 1'b0, 32'd1, VALUE_W'(5), 32'd2);
		issue(FUNC_BUILD, 1'b0, 32'd9, VALUE_W'(28), 32'd9);
		issue(FUNC_BUILD, 1'b0, 32'd3, VALUE_W'(5), 32'd4);
		issue(FUNC_BUILD, 1'b0, 32'd5, VALUE_W'(5), 32'd6);
		issue(FUNC_PROBE, 1'b0, '1, '0, '1);
		issue(FUNC_PROBE, 1'b0, '0, '1, '0);
		issue(FUNC_PROBE, 1'b0, 32'h0000_0077, VALUE_W'(5), 32'h0000_0088);
		issue(FUNC_PROBE, 1'b0, 32'h0000_0011, VALUE_W'(28), 32'h0000_0022);
		issue(FUNC_PROBE, 1'b0, 32'h0000_0033, VALUE_W'(51), 32'h0000_0044);
		issue(FUNC_PROBE, 1'b0, 32'h0000_0055, VALUE_W'(6), 32'h0000_0066);
		drain();
		set_side(1'b1);
		issue(FUNC_PROBE, 1'b1, 32'hA5A5_A5A5, VALUE_W'(5), 32'h5A5A_5A5A);
		issue(FUNC_PROBE, 1'b0, 32'h1234_5678, '0, 32'h8765_4321);
		// a new partition drops everything stored so far
		issue(FUNC_BUILD, 1'b1, 32'h0000_0046, VALUE_W'(46), 32'h0000_0046);
		issue(FUNC_PROBE, 1'b0, '1, '0, '1);
		issue(FUNC_PROBE, 1'b0, '1, VALUE_W'(5), '1);
		issue(FUNC_PROBE, 1'b1, '0, VALUE_W'(46), '0);
		issue(FUNC_BUILD, 1'b0, '1, '0, '0);
		issue(FUNC_PROBE, 1'b0, '0, '0, '1);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			set_side(ph == 2 ? 1'($urandom_range(1)) : ph == 0);
			idle_pct    = (ph == 0) ? 16 : (ph == 1) ? 80 : 0;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				run_partition();
				if ($urandom_range(5) == 0) begin
					drain();
					set_side(1'($urandom_range(1)));
				end
			end
			drain();
		end

		// fill the store with one value, then push past its depth
		set_side(1'($urandom_range(1)));
		idle_pct = 16;
		k = VALUE_W'($urandom_range(32'h7FFF_FF00, 0));
		for (int i = 0; i < BUCKET_DEPTH + 3; i++) begin
			build(i == 0, k);
		end
		probe(k);
		probe(k + VALUE_W'(HASH_MODULUS));
		// a partition start on a full store is still taken
		build(1'b1, k + VALUE_W'(HASH_MODULUS));
		probe(k + VALUE_W'(HASH_MODULUS));
		probe(k);
		drain();

		$display("covered %0d build and %0d probe transactions, %0d pairs checked, %0d side writes",
			build_total, probe_total, pairs_checked, side_writes);
		$display("both pair orders, slot collisions, a full-depth chain and store overflow exercised");
		if (fail_count == 0) begin
			$display("bucket_chain_hash_join regression: pass");
		end else begin
			$display("bucket_chain_hash_join regression: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/bchj_pkg.sv
design/bucket_chain_hash_join.sv
design/bchj_checker.sv
verif/bchj_checker.sv
verif/tb.sv
